// ===== design/erpp_pkg.sv =====
// shared types, constants, sine table and trig helpers for the point projector
package erpp_pkg;

  localparam int TRIG_FRAC_BITS  = 15;
  localparam int COORD_FRAC_BITS = 16;

  localparam int TW    = TRIG_FRAC_BITS + 1;   // signed sine / cosine
  localparam int MW    = TRIG_FRAC_BITS + 2;   // signed matrix entry
  localparam int PRW   = MW + 32;              // entry times coordinate
  localparam int RW    = PRW - TRIG_FRAC_BITS + 1;
  localparam int DW    = RW + 2;               // translated coordinate
  localparam int SPLIT = 18;                   // low slice of the magnitude
  localparam int LPW   = SPLIT + 32;
  localparam int HPW   = DW - SPLIT + 32;
  localparam int PW    = DW + 32;              // magnitude times view scale
  localparam int NW    = PW - COORD_FRAC_BITS; // dividend after the depth shift
  localparam int PROJ_CAP_BITS = 20;
  localparam int QB    = PROJ_CAP_BITS + 1;    // quotient bits kept
  localparam int CMW   = (NW - QB > DW) ? NW - QB : DW;
  localparam int SQW   = QB + 2;
  localparam int OW    = QB + 3;

  localparam int DEG_QUARTER = 90;
  localparam int DEG_HALF    = 180;
  localparam int DEG_3Q      = 270;
  localparam int DEG_FULL    = 360;
  localparam int SCREEN_COL_BIAS = 80;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam int SER_TERMS = 8;
  localparam logic [63:0] SER_DIV [SER_TERMS] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

  typedef enum logic [2:0] {
    REG_ALPHA,
    REG_BETA,
    REG_GAMMA,
    REG_SHIFT_X,
    REG_SHIFT_Y,
    REG_SHIFT_Z,
    REG_VIEW_SCALE,
    REG_SCREEN_DIMS
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] screen_column;
    logic signed [15:0] screen_row;
    logic               zero_depth;
  } out_item_t;

  typedef struct packed {
    logic [DW-1:0] den;
    logic [QB-1:0] nlo_x;
    logic [QB-1:0] nlo_z;
    logic [DW-1:0] rem_x;
    logic [DW-1:0] rem_z;
    logic [QB-1:0] q_x;
    logic [QB-1:0] q_z;
    logic          over_x;
    logic          over_z;
    logic          nz_x;
    logic          nz_z;
    logic          sgn_x;
    logic          sgn_z;
    logic          zd;
  } div_stage_t;

  typedef logic [TRIG_FRAC_BITS-1:0] sin_tbl_t [DEG_QUARTER+1];

  // series evaluation in q30, rounded to the trig format
  function automatic sin_tbl_t build_sin_tbl();
    sin_tbl_t           tbl;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        r;
    logic [63:0]        half;
    logic [63:0]        cap;
    logic signed [63:0] sum;
    half = (64'd1 << (30 - TRIG_FRAC_BITS)) >> 1;
    cap  = (64'd1 << TRIG_FRAC_BITS) - 64'd1;
    for (int d = 0; d <= DEG_QUARTER; d++) begin
      x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum  = $signed(x);
      for (int k = 0; k < SER_TERMS; k++) begin
        term = ((term * x2 + (64'd1 << 29)) >> 30) / SER_DIV[k];
        if (k[0] == 1'b0) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      r = ($unsigned(sum) + half) >> (30 - TRIG_FRAC_BITS);
      if (r > cap) begin
        r = cap;
      end
      tbl[d] = r[TRIG_FRAC_BITS-1:0];
    end
    return tbl;
  endfunction

  localparam sin_tbl_t SIN_TBL = build_sin_tbl();

  function automatic logic [8:0] deg_wrap(logic [8:0] d);
    return (d >= 9'(DEG_FULL)) ? 9'(d - 9'(DEG_FULL)) : d;
  endfunction

  // quadrant fold onto the quarter table, d already below a full turn
  function automatic logic signed [TW-1:0] sin_fold(logic [8:0] d);
    logic [8:0] idx;
    logic       neg;
    if (d <= 9'(DEG_QUARTER)) begin
      idx = d;
      neg = 1'b0;
    end else if (d <= 9'(DEG_HALF)) begin
      idx = 9'(DEG_HALF) - d;
      neg = 1'b0;
    end else if (d <= 9'(DEG_3Q)) begin
      idx = d - 9'(DEG_HALF);
      neg = 1'b1;
    end else begin
      idx = 9'(DEG_FULL) - d;
      neg = 1'b1;
    end
    return neg ? -$signed({1'b0, SIN_TBL[idx[6:0]]}) : $signed({1'b0, SIN_TBL[idx[6:0]]});
  endfunction

  function automatic logic signed [TW-1:0] cos_fold(logic [8:0] d);
    return sin_fold(deg_wrap(deg_wrap(d) + 9'(DEG_QUARTER)));
  endfunction

  // product of two trig values, rounded half away from zero
  function automatic logic signed [TW-1:0] tmul(logic signed [TW-1:0] a,
                                                logic signed [TW-1:0] b);
    logic signed [2*TW-1:0] p;
    logic [2*TW-1:0]        m;
    logic [2*TW-1:0]        s;
    logic [TW-1:0]          mag;
    p   = (2*TW)'(a) * (2*TW)'(b);
    m   = p[2*TW-1] ? $unsigned(-p) : $unsigned(p);
    s   = (m + ((2*TW)'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
    mag = s[TW-1:0];
    return p[2*TW-1] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ===== design/euler_rotate_perspective_project.sv =====
// point projector: zxz euler rotation, translation and perspective divide
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    in_item_t  (px, py, pz)
//   out       output     out_valid/out_ready  out_item_t (column, row, zero_depth)
//   config    input      apb psel/penable     8 registers at 4*index
//
// one item per cycle while the skid is empty; the path from accept to the
// output register is set mostly by the 21 quotient bit stages of the divider
// the rotation matrix is rebuilt from the angle registers in a free running
// 3 stage chain, items read it only at their product stage
// reset clears valid bits and config registers, no clearing pass
// a one entry skid behind the output register takes the item leaving the
// pipe when out is stalled; the pipe then holds until the skid drains
module euler_rotate_perspective_project
  import erpp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NSTG = 9 + QB + 2;  // item stages 0..8, divider, result

  // ---------------- configuration registers ----------------
  logic [8:0]         alpha_q, beta_q, gamma_q;
  logic signed [31:0] shift_x_q, shift_y_q, shift_z_q;
  logic [31:0]        view_scale_q, screen_dims_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q       <= '0;
      beta_q        <= '0;
      gamma_q       <= '0;
      shift_x_q     <= '0;
      shift_y_q     <= 32'hFED4_0000;  // -300.0
      shift_z_q     <= '0;
      view_scale_q  <= 32'h0001_0000;  // 1.0
      screen_dims_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ALPHA:       alpha_q       <= pwdata[8:0];
        REG_BETA:        beta_q        <= pwdata[8:0];
        REG_GAMMA:       gamma_q       <= pwdata[8:0];
        REG_SHIFT_X:     shift_x_q     <= pwdata;
        REG_SHIFT_Y:     shift_y_q     <= pwdata;
        REG_SHIFT_Z:     shift_z_q     <= pwdata;
        REG_VIEW_SCALE:  view_scale_q  <= pwdata;
        REG_SCREEN_DIMS: screen_dims_q <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ALPHA:       prdata = 32'(alpha_q);
      REG_BETA:        prdata = 32'(beta_q);
      REG_GAMMA:       prdata = 32'(gamma_q);
      REG_SHIFT_X:     prdata = shift_x_q;
      REG_SHIFT_Y:     prdata = shift_y_q;
      REG_SHIFT_Z:     prdata = shift_z_q;
      REG_VIEW_SCALE:  prdata = view_scale_q;
      REG_SCREEN_DIMS: prdata = screen_dims_q;
    endcase
  end

  // ---------------- matrix chain ----------------
  // stage 1: sines and cosines
  logic signed [TW-1:0] sa_q, ca_q, sb_q, cb_q, sg_q, cg_q;
  always_ff @(posedge clk_i) begin
    sa_q <= sin_fold(deg_wrap(alpha_q));
    ca_q <= cos_fold(alpha_q);
    sb_q <= sin_fold(deg_wrap(beta_q));
    cb_q <= cos_fold(beta_q);
    sg_q <= sin_fold(deg_wrap(gamma_q));
    cg_q <= cos_fold(gamma_q);
  end

  // stage 2: pair products
  logic signed [TW-1:0] cg_ca_q, cb_sg_q, ca_sg_q, cg_cb_q, sb_sa_q, cb_ca_q;
  logic signed [TW-1:0] cg_sa_q, sg_sa_q, ca_sb_q, sg_sb_q, cg_sb_q;
  logic signed [TW-1:0] sa2_q, ca2_q, sg2_q, cb2_q;
  always_ff @(posedge clk_i) begin
    cg_ca_q <= tmul(cg_q, ca_q);
    cb_sg_q <= tmul(cb_q, sg_q);
    ca_sg_q <= tmul(ca_q, sg_q);
    cg_cb_q <= tmul(cg_q, cb_q);
    sb_sa_q <= tmul(sb_q, sa_q);
    cb_ca_q <= tmul(cb_q, ca_q);
    cg_sa_q <= tmul(cg_q, sa_q);
    sg_sa_q <= tmul(sg_q, sa_q);
    ca_sb_q <= tmul(ca_q, sb_q);
    sg_sb_q <= tmul(sg_q, sb_q);
    cg_sb_q <= tmul(cg_q, sb_q);
    sa2_q   <= sa_q;
    ca2_q   <= ca_q;
    sg2_q   <= sg_q;
    cb2_q   <= cb_q;
  end

  // stage 3: entries, row-major, columns for x, y, z
  logic signed [MW-1:0] m_q [9];
  always_ff @(posedge clk_i) begin
    m_q[0] <= MW'(cg_ca_q) - MW'(tmul(cb_sg_q, sa2_q));
    m_q[1] <= MW'(ca_sg_q) + MW'(tmul(cg_cb_q, sa2_q));
    m_q[2] <= MW'(sb_sa_q);
    m_q[3] <= -(MW'(tmul(cb_ca_q, sg2_q)) + MW'(cg_sa_q));
    m_q[4] <= MW'(tmul(cg_cb_q, ca2_q)) - MW'(sg_sa_q);
    m_q[5] <= MW'(ca_sb_q);
    m_q[6] <= MW'(sg_sb_q);
    m_q[7] <= -MW'(cg_sb_q);
    m_q[8] <= MW'(cb2_q);
  end

  // ---------------- item pipeline control ----------------
  logic [NSTG-1:0] v_q;
  logic            en;
  logic            skid_v_q;
  logic            out_v_q;
  out_item_t       skid_q, out_q, res_q;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  // ---------------- rotation ----------------
  in_item_t pt0_q, pt1_q, pt2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      pt0_q <= in_data_i;
      pt1_q <= pt0_q;
      pt2_q <= pt1_q;  // lets the matrix settle after an angle write
    end
  end

  logic signed [31:0] coord [3];
  assign coord[0] = pt2_q.px;
  assign coord[1] = pt2_q.py;
  assign coord[2] = pt2_q.pz;

  function automatic logic signed [RW-1:0] rnd_coord(logic signed [PRW-1:0] p);
    logic [PRW-1:0] m;
    logic [PRW:0]   s;
    logic [RW-1:0]  mag;
    m   = p[PRW-1] ? $unsigned(-p) : $unsigned(p);
    s   = (PRW+1)'(m) + ((PRW+1)'(1) << (TRIG_FRAC_BITS - 1));
    mag = RW'(s >> TRIG_FRAC_BITS);
    return p[PRW-1] ? -$signed(mag) : $signed(mag);
  endfunction

  logic signed [PRW-1:0] prod_q [9];
  logic signed [RW-1:0]  rnd_q [9];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        prod_q[k] <= PRW'(m_q[k]) * PRW'(coord[k % 3]);
        rnd_q[k]  <= rnd_coord(prod_q[k]);
      end
    end
  end

  // row sums plus translation
  logic signed [DW-1:0] tx_q, ty_q, tz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      tx_q <= DW'(rnd_q[0]) + DW'(rnd_q[1]) + DW'(rnd_q[2]) + DW'(shift_x_q);
      ty_q <= DW'(rnd_q[3]) + DW'(rnd_q[4]) + DW'(rnd_q[5]) + DW'(shift_y_q);
      tz_q <= DW'(rnd_q[6]) + DW'(rnd_q[7]) + DW'(rnd_q[8]) + DW'(shift_z_q);
    end
  end

  // ---------------- magnitudes and scale ----------------
  logic [DW-1:0]  ax6_q, az6_q, den6_q, den7_q, den8_q;
  logic           sx6_q, sz6_q, zd6_q, sx7_q, sz7_q, zd7_q, sx8_q, sz8_q, zd8_q;
  logic [LPW-1:0] lox_q, loz_q;
  logic [HPW-1:0] hix_q, hiz_q;
  logic [PW-1:0]  fx, fz;
  logic [NW-1:0]  nx8_q, nz8_q;
  logic           nzx8_q, nzz8_q;

  assign fx = PW'(lox_q) + (PW'(hix_q) << SPLIT);
  assign fz = PW'(loz_q) + (PW'(hiz_q) << SPLIT);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax6_q  <= tx_q[DW-1] ? $unsigned(-tx_q) : $unsigned(tx_q);
      az6_q  <= tz_q[DW-1] ? $unsigned(-tz_q) : $unsigned(tz_q);
      den6_q <= ty_q[DW-1] ? $unsigned(-ty_q) : $unsigned(ty_q);
      sx6_q  <= tx_q[DW-1];
      sz6_q  <= tz_q[DW-1];
      zd6_q  <= (ty_q == '0);
      // magnitude split in two slices against the 32 bit scale
      lox_q  <= LPW'(ax6_q[SPLIT-1:0]) * LPW'(view_scale_q);
      hix_q  <= HPW'(ax6_q[DW-1:SPLIT]) * HPW'(view_scale_q);
      loz_q  <= LPW'(az6_q[SPLIT-1:0]) * LPW'(view_scale_q);
      hiz_q  <= HPW'(az6_q[DW-1:SPLIT]) * HPW'(view_scale_q);
      den7_q <= den6_q;
      sx7_q  <= sx6_q;
      sz7_q  <= sz6_q;
      zd7_q  <= zd6_q;
      // dividing by depth << frac equals dividing the shifted product by depth
      nx8_q  <= fx[PW-1:COORD_FRAC_BITS];
      nz8_q  <= fz[PW-1:COORD_FRAC_BITS];
      nzx8_q <= (fx != '0);
      nzz8_q <= (fz != '0);
      den8_q <= den7_q;
      sx8_q  <= sx7_q;
      sz8_q  <= sz7_q;
      zd8_q  <= zd7_q;
    end
  end

  // ---------------- divider ----------------
  // overflow check first: quotient at or above 2^QB caps, as does zero depth with a nonzero numerator
  div_stage_t dv_q [QB+1];
  div_stage_t dv0_d;
  logic [NW-QB-1:0] hx, hz;

  assign hx = nx8_q[NW-1:QB];
  assign hz = nz8_q[NW-1:QB];

  always_comb begin
    dv0_d.den    = den8_q;
    dv0_d.nlo_x  = nx8_q[QB-1:0];
    dv0_d.nlo_z  = nz8_q[QB-1:0];
    dv0_d.rem_x  = DW'(hx);
    dv0_d.rem_z  = DW'(hz);
    dv0_d.q_x    = '0;
    dv0_d.q_z    = '0;
    dv0_d.over_x = CMW'(hx) >= CMW'(den8_q);
    dv0_d.over_z = CMW'(hz) >= CMW'(den8_q);
    dv0_d.nz_x   = nzx8_q;
    dv0_d.nz_z   = nzz8_q;
    dv0_d.sgn_x  = sx8_q;
    dv0_d.sgn_z  = sz8_q;
    dv0_d.zd     = zd8_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0] <= dv0_d;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [DW:0] r2x, r2z;
    div_stage_t  nxt;

    assign r2x = {dv_q[j].rem_x, dv_q[j].nlo_x[QB-1-j]};
    assign r2z = {dv_q[j].rem_z, dv_q[j].nlo_z[QB-1-j]};

    always_comb begin
      nxt = dv_q[j];
      if (r2x >= {1'b0, dv_q[j].den}) begin
        nxt.rem_x         = DW'(r2x - {1'b0, dv_q[j].den});
        nxt.q_x[QB-1-j]   = 1'b1;
      end else begin
        nxt.rem_x         = r2x[DW-1:0];
      end
      if (r2z >= {1'b0, dv_q[j].den}) begin
        nxt.rem_z         = DW'(r2z - {1'b0, dv_q[j].den});
        nxt.q_z[QB-1-j]   = 1'b1;
      end else begin
        nxt.rem_z         = r2z[DW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[j+1] <= nxt;
      end
    end
  end

  // ---------------- screen placement ----------------
  localparam logic [QB-1:0] PROJ_CAP = QB'(1) << PROJ_CAP_BITS;

  function automatic logic [QB-1:0] cap_q(logic [QB-1:0] q, logic over, logic nz);
    if (!nz) begin
      return '0;
    end else if (over || (q[QB-1] && (q[QB-2:0] != '0))) begin
      return PROJ_CAP;
    end else begin
      return q;
    end
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [OW-1:0] v);
    if (v > OW'(32767)) begin
      return 16'sh7FFF;
    end else if (v < -OW'(32768)) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  div_stage_t           dl;
  logic [QB-1:0]        qx, qz;
  logic signed [SQW-1:0] sqx, sqz;
  logic [16:0]          ch;
  logic [14:0]          cw;
  logic signed [OW-1:0] col, row;
  out_item_t            res_d;

  assign dl  = dv_q[QB];
  assign qx  = cap_q(dl.q_x, dl.over_x, dl.nz_x);
  assign qz  = cap_q(dl.q_z, dl.over_z, dl.nz_z);
  assign sqx = dl.sgn_x ? -$signed(SQW'(qx)) : $signed(SQW'(qx));
  assign sqz = dl.sgn_z ? -$signed(SQW'(qz)) : $signed(SQW'(qz));
  // column centred on (height + bias) / 2, row on width / 2
  assign ch  = (17'(screen_dims_q[15:0]) + 17'(SCREEN_COL_BIAS)) >> 1;
  assign cw  = screen_dims_q[31:17];
  assign col = $signed(OW'(ch)) + OW'(sqx);
  assign row = $signed(OW'(cw)) - OW'(sqz);

  always_comb begin
    res_d.screen_column = sat16(col);
    res_d.screen_row    = sat16(row);
    res_d.zero_depth    = dl.zd;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  // ---------------- output register and skid ----------------
  logic leave;
  assign leave = en & v_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      out_v_q  <= skid_v_q | leave;
      skid_v_q <= 1'b0;
    end else if (leave) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_q <= skid_v_q ? skid_q : res_q;
    end else if (leave) begin
      skid_q <= res_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule
